@@ rtl/mssb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssb_pkg
// shared widths, defaults and sequencer states for the max run sum block
// ----------------------------------------------------------------------------
package mssb_pkg;

  localparam int MAX_LEN_DEF = 63;
  localparam int SAMPLE_W    = 16;
  localparam int BOOST_W     = 16;
  localparam int ANSWER_W    = 23;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_ZERO,
    ST_RD,
    ST_CALC,
    ST_SEND
  } mssb_state_t;

endpackage

@@ rtl/mssb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssb_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module mssb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/max_subarray_sum_by_length_boost.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_subarray_sum_by_length_boost
// best run sum per run length with a per element boost, one shared subtractor
// ----------------------------------------------------------------------------
// usage
//   in_*  : one signed sample per transfer; in_is_last ends the sequence and
//           starts the compute. samples are taken one per cycle while idle.
//   cfg_* : boost register, always ready, write only while the block is idle.
//   out_* : n+1 results (k = 0..n), out_last_answer on the one for k = n,
//           out_overflow on all of them when more than MAX_LEN samples came.
// sweep and results
//   the sweep runs one (length, start) pair per cycle through a single
//   prefix-sum subtractor and compare; ST_DRAIN, ST_ZERO and ST_RD then
//   drain the pipeline and set up the answer pass.
//   each result then takes a best ram read, then an add and compare,
//   and waits while the receiver stalls; in_stall stays high until the
//   final result has been transferred.
// reset
//   rst_n (synchronous) clears sample count, overflow flag, boost and the
//   sequencer; the rams hold no reset state and need no clearing.
// stall
//   a stalled result holds in the output register; the sequencer waits.
// ----------------------------------------------------------------------------
module max_subarray_sum_by_length_boost
  import mssb_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // sample channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_is_last,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ANSWER_W-1:0] out_answer,
  output logic                out_last_answer,
  output logic                out_overflow,
  // boost register
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [BOOST_W-1:0]  cfg_data
);

  localparam int IW    = $clog2(MAX_LEN + 1);  // index / count width
  localparam int PW    = SAMPLE_W + IW;        // prefix sum width
  localparam int CW    = ANSWER_W + 1;         // signed candidate width
  localparam int DEPTH = MAX_LEN + 1;

  // control state
  mssb_state_t state_r, state_nxt;
  logic [IW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [BOOST_W-1:0] boost_r, boost_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          p_vld_r, p_vld_nxt;
  logic          suf_have_r, suf_have_nxt;

  // datapath state
  logic signed [PW-1:0] prefix_r, prefix_nxt;
  logic [IW-1:0]        a_r, a_nxt;       // run length being swept
  logic [IW-1:0]        b_r, b_nxt;       // run start being swept
  logic [IW-1:0]        k_r, k_nxt;       // result index
  logic                 p_first_r, p_first_nxt;
  logic                 p_lastb_r, p_lastb_nxt;
  logic [IW-1:0]        p_a_r, p_a_nxt;
  logic signed [PW-1:0] cur_r, cur_nxt;   // best of current length
  logic signed [PW-1:0] suf_r, suf_nxt;   // running suffix max
  logic signed [CW-1:0] ans_r, ans_nxt;
  logic [ANSWER_W-1:0]  out_answer_r, out_answer_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  // ram ports
  logic          pfx_we;
  logic [IW-1:0] pfx_waddr;
  logic [PW-1:0] pfx_wdata;
  logic [IW-1:0] lo_raddr, hi_raddr;
  logic [PW-1:0] lo_rdata, hi_rdata;
  logic          best_we;
  logic [IW-1:0] best_waddr, best_raddr;
  logic [PW-1:0] best_wdata, best_rdata;

  // shared arithmetic
  logic signed [PW-1:0]          sample_ext;
  logic signed [PW-1:0]          run_sum;
  logic signed [PW-1:0]          new_best;
  logic signed [PW-1:0]          new_suf;
  logic [IW+BOOST_W-1:0]         prod;
  logic signed [CW-1:0]          cand;
  logic                          in_xfer, out_xfer, last_b;

  // two copies of the prefix sums so both ends of a run are read in the same cycle
  mssb_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_pfx_lo (
    .clk     (clk),
    .wr_en   (pfx_we),
    .wr_addr (pfx_waddr),
    .wr_data (pfx_wdata),
    .rd_addr (lo_raddr),
    .rd_data (lo_rdata)
  );

  mssb_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_pfx_hi (
    .clk     (clk),
    .wr_en   (pfx_we),
    .wr_addr (pfx_waddr),
    .wr_data (pfx_wdata),
    .rd_addr (hi_raddr),
    .rd_data (hi_rdata)
  );

  // suffix maxima per length
  mssb_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_best (
    .clk     (clk),
    .wr_en   (best_we),
    .wr_addr (best_waddr),
    .wr_data (best_wdata),
    .rd_addr (best_raddr),
    .rd_data (best_rdata)
  );

  assign in_stall        = (state_r != ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_answer      = out_answer_r;
  assign out_last_answer = out_last_r;
  assign out_overflow    = out_ovf_r;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  assign sample_ext = {{IW{in_sample[SAMPLE_W-1]}}, in_sample};

  // run sum from prefix sums; prefix at position 0 is zero and not stored
  assign run_sum  = $signed(hi_rdata) - (p_first_r ? '0 : $signed(lo_rdata));
  assign new_best = (p_first_r || run_sum > cur_r) ? run_sum : cur_r;
  assign new_suf  = (!suf_have_r || new_best > suf_r) ? new_best : suf_r;
  assign last_b   = (b_r == count_r - a_r);

  // answer pass: best[k] + k*boost
  assign prod = k_r * boost_r;
  assign cand = {{(CW-PW){best_rdata[PW-1]}}, best_rdata}
              + $signed({{(CW-IW-BOOST_W){1'b0}}, prod});

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    boost_nxt      = boost_r;
    out_valid_nxt  = out_valid_r;
    p_vld_nxt      = 1'b0;
    suf_have_nxt   = suf_have_r;
    prefix_nxt     = prefix_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    k_nxt          = k_r;
    p_first_nxt    = (b_r == '0);
    p_lastb_nxt    = last_b;
    p_a_nxt        = a_r;
    cur_nxt        = cur_r;
    suf_nxt        = suf_r;
    ans_nxt        = ans_r;
    out_answer_nxt = out_answer_r;
    out_last_nxt   = out_last_r;
    out_ovf_nxt    = out_ovf_r;

    pfx_we     = 1'b0;
    pfx_waddr  = count_r + 1'b1;
    pfx_wdata  = prefix_r + sample_ext;
    lo_raddr   = b_r;
    hi_raddr   = b_r + a_r;
    best_we    = 1'b0;
    best_waddr = p_a_r;
    best_wdata = new_suf;
    best_raddr = k_r;

    if (cfg_valid && cfg_ready) begin
      boost_nxt = cfg_data;
    end

    // compare stage of the sweep, in the cycle after the ram reads are issued
    if (p_vld_r) begin
      cur_nxt = new_best;
      if (p_lastb_r) begin
        best_we      = 1'b1;
        suf_nxt      = new_suf;
        suf_have_nxt = 1'b1;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (count_r < IW'(MAX_LEN)) begin
            pfx_we     = 1'b1;
            prefix_nxt = prefix_r + sample_ext;
            count_nxt  = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_is_last) begin
            a_nxt        = (count_r < IW'(MAX_LEN)) ? count_r + 1'b1 : count_r;
            b_nxt        = '0;
            suf_have_nxt = 1'b0;
            state_nxt    = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        p_vld_nxt = 1'b1;
        if (last_b) begin
          b_nxt = '0;
          if (a_r == IW'(1)) begin
            state_nxt = ST_DRAIN;
          end else begin
            a_nxt = a_r - 1'b1;
          end
        end else begin
          b_nxt = b_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_ZERO;
      end
      ST_ZERO: begin
        // length zero gives zero, so its suffix max is never negative
        best_we    = 1'b1;
        best_waddr = '0;
        best_wdata = (suf_r > 0) ? suf_r : '0;
        k_nxt      = '0;
        ans_nxt    = '0;
        state_nxt  = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        if (cand > ans_r) begin
          ans_nxt        = cand;
          out_answer_nxt = cand[ANSWER_W-1:0];
        end else begin
          out_answer_nxt = ans_r[ANSWER_W-1:0];
        end
        out_last_nxt  = (k_r == count_r);
        out_ovf_nxt   = ovf_r;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_SEND;
      end
      ST_SEND: begin
        best_raddr = k_r + 1'b1;
        if (out_xfer) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            count_nxt  = '0;
            ovf_nxt    = 1'b0;
            prefix_nxt = '0;
            state_nxt  = ST_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_CALC;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      boost_r     <= '0;
      out_valid_r <= 1'b0;
      p_vld_r     <= 1'b0;
      suf_have_r  <= 1'b0;
      prefix_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      boost_r     <= boost_nxt;
      out_valid_r <= out_valid_nxt;
      p_vld_r     <= p_vld_nxt;
      suf_have_r  <= suf_have_nxt;
      prefix_r    <= prefix_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    k_r          <= k_nxt;
    p_first_r    <= p_first_nxt;
    p_lastb_r    <= p_lastb_nxt;
    p_a_r        <= p_a_nxt;
    cur_r        <= cur_nxt;
    suf_r        <= suf_nxt;
    ans_r        <= ans_nxt;
    out_answer_r <= out_answer_nxt;
    out_last_r   <= out_last_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

endmodule

@@ rtl/mssb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssb_checker
// port level checks on the result channel of the max run sum block
// ----------------------------------------------------------------------------
module mssb_checker
  import mssb_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [ANSWER_W-1:0] out_answer,
  input logic                out_last_answer,
  input logic                out_overflow
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_answer)
      && $stable(out_last_answer))
    else $error("stalled result changed");

  // no sample is taken while results are pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while a result waits");

  // a non-final transfer is followed by a gap with out_valid low, then the next result
  a_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_answer |=> !out_valid ##1 out_valid)
    else $error("next result not presented on time");

  // answers never shrink and the overflow flag holds within one sequence
  a_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_answer |-> ##2
      (out_answer >= $past(out_answer, 2)) && (out_overflow == $past(out_overflow, 2)))
    else $error("answer decreased or overflow changed within a sequence");

endmodule

bind max_subarray_sum_by_length_boost mssb_checker u_mssb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_answer      (out_answer),
  .out_last_answer (out_last_answer),
  .out_overflow    (out_overflow)
);
